/* sv/rsc_pkg.sv */
// Shared types and constants for the range sensor command controller.
// No dependencies; rsc_cfg and the controller refer to it by scoped names.
package rsc_pkg;

    // Count at which an endless multi-scan run folds its sent counter back to zero
    localparam int unsigned ENDLESS_WRAP = 100;

    localparam int unsigned STEP_W   = 14;
    localparam int unsigned WINDOW_W = 16;
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 32;

    typedef enum logic [3:0] {
        K_BM           = 4'd0,
        K_QT           = 4'd1,
        K_RS           = 4'd2,
        K_TM           = 4'd3,
        K_MX           = 4'd4,
        K_RB           = 4'd5,
        K_UNKNOWN      = 4'd6,
        K_SCAN_TICK    = 4'd7,
        K_REBOOT_START = 4'd8,
        K_BOOT_DONE    = 4'd9,
        K_DISCONNECT   = 4'd10,
        K_FORCE_STATE  = 4'd11
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_BOOTING = 3'd1,
        ST_SINGLE  = 3'd2,
        ST_MULTI   = 3'd3,
        ST_TIMEADJ = 3'd4,
        ST_ERROR   = 3'd5
    } state_t;

    typedef enum logic [3:0] {
        S_00 = 4'd0,
        S_01 = 4'd1,
        S_02 = 4'd2,
        S_03 = 4'd3,
        S_04 = 4'd4,
        S_05 = 4'd5,
        S_0C = 4'd6,
        S_0D = 4'd7,
        S_0E = 4'd8,
        S_0L = 4'd9,
        S_10 = 4'd10,
        S_99 = 4'd11
    } status_t;

    typedef enum logic [1:0] {
        LEN_OK    = 2'd0,
        LEN_SHORT = 2'd1,
        LEN_LONG  = 2'd2
    } len_t;

    typedef enum logic [1:0] {
        TM_ENTER = 2'd0,
        TM_READ  = 2'd1,
        TM_LEAVE = 2'd2,
        TM_OTHER = 2'd3
    } tm_t;

    typedef enum logic [1:0] {
        REG_MIN_STEP  = 2'd0,
        REG_MAX_STEP  = 2'd1,
        REG_RB_WINDOW = 2'd2
    } reg_idx_t;

    localparam logic [STEP_W-1:0]   MIN_STEP_RST  = 14'd0;
    localparam logic [STEP_W-1:0]   MAX_STEP_RST  = 14'd1080;
    localparam logic [WINDOW_W-1:0] RB_WINDOW_RST = 16'd1000;

    typedef struct packed {
        logic [STEP_W-1:0]   min_step;
        logic [STEP_W-1:0]   max_step;
        logic [WINDOW_W-1:0] reboot_window_ms;
    } cfg_t;

endpackage

/* sv/rsc_if.sv */
// Command and reply channel interfaces for the range sensor controller.
// Depends on nothing; widths follow the field list of the block.
interface rsc_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [1:0]  length_status;
    logic [1:0]  tm_sub;
    logic        with_intensity;
    logic        fields_valid;
    logic [13:0] start_step;
    logic [13:0] end_step;
    logic [6:0]  group_size;
    logic [3:0]  skip_scans;
    logic [6:0]  scan_total;
    logic [31:0] now_ms;
    logic [2:0]  forced_state;

    modport source (
        output valid, kind, length_status, tm_sub, with_intensity, fields_valid,
               start_step, end_step, group_size, skip_scans, scan_total, now_ms,
               forced_state,
        input  ready
    );
    modport sink (
        input  valid, kind, length_status, tm_sub, with_intensity, fields_valid,
               start_step, end_step, group_size, skip_scans, scan_total, now_ms,
               forced_state,
        output ready
    );
endinterface

interface rsc_rsp_if;
    logic        valid;
    logic        ready;
    logic        reply_valid;
    logic [3:0]  status;
    logic [2:0]  sensor_state;
    logic        send_timestamp;
    logic [6:0]  scans_left;
    logic        frame_intensity;
    logic        epoch_reset;
    logic        reboot_scheduled;
    logic [15:0] boots;

    modport source (
        output valid, reply_valid, status, sensor_state, send_timestamp, scans_left,
               frame_intensity, epoch_reset, reboot_scheduled, boots,
        input  ready
    );
    modport sink (
        input  valid, reply_valid, status, sensor_state, send_timestamp, scans_left,
               frame_intensity, epoch_reset, reboot_scheduled, boots,
        output ready
    );
endinterface

/* sv/rsc_cfg.sv */
// APB-style configuration registers of the range sensor controller.
// Depends on rsc_pkg for the register indexes, reset values and cfg_t.
module rsc_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rsc_pkg::PADDR_W-1:0]  paddr,
    input  logic [rsc_pkg::PDATA_W-1:0]  pwdata,
    output logic [rsc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output rsc_pkg::cfg_t                cfg
);

    rsc_pkg::cfg_t cfg_reg;
    logic [1:0]    idx;
    logic          wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[rsc_pkg::PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_step         <= rsc_pkg::MIN_STEP_RST;
            cfg_reg.max_step         <= rsc_pkg::MAX_STEP_RST;
            cfg_reg.reboot_window_ms <= rsc_pkg::RB_WINDOW_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                rsc_pkg::REG_MIN_STEP:  cfg_reg.min_step <= pwdata[rsc_pkg::STEP_W-1:0];
                rsc_pkg::REG_MAX_STEP:  cfg_reg.max_step <= pwdata[rsc_pkg::STEP_W-1:0];
                rsc_pkg::REG_RB_WINDOW:
                    cfg_reg.reboot_window_ms <= pwdata[rsc_pkg::WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            rsc_pkg::REG_MIN_STEP:  prdata = {18'd0, cfg_reg.min_step};
            rsc_pkg::REG_MAX_STEP:  prdata = {18'd0, cfg_reg.max_step};
            rsc_pkg::REG_RB_WINDOW: prdata = {16'd0, cfg_reg.reboot_window_ms};
            default:                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* sv/range_sensor_command_state_machine.sv */
// Range sensor command controller: state, multi-scan settings, counters.
// Depends on rsc_pkg, rsc_if (rsc_cmd_if, rsc_rsp_if) and rsc_cfg.
//
// Usage:
//   cmd carries one decoded command, scan tick or lifecycle event per beat;
//   rsp returns exactly one result beat for every cmd beat, in order.
//   Configuration (min_step, max_step, reboot_window_ms) is written through
//   the APB-style port at byte addresses 0, 4 and 8 while the block is idle.
// Decode and throughput:
//   An accepted beat is decoded against the current state in the same cycle;
//   state and the result register load at that edge, so the result is shown
//   in the cycle after acceptance. One beat per cycle is sustained while
//   rsp.ready stays high.
// Stall:
//   cmd.ready drops only while a result is held and rsp.ready is low; the
//   result register holds until it is taken, and the next beat follows in the
//   cycle that it leaves.
// Reset:
//   rst_n clears the result valid flag and puts the sensor into booting with
//   cleared settings (group size 1) and counters; config registers take their defaults.
module range_sensor_command_state_machine #(
    parameter int unsigned ENDLESS_WRAP = rsc_pkg::ENDLESS_WRAP
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rsc_pkg::PADDR_W-1:0] paddr,
    input  logic [rsc_pkg::PDATA_W-1:0] pwdata,
    output logic [rsc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    rsc_cmd_if.sink                     cmd,
    rsc_rsp_if.source                   rsp
);

    localparam logic [6:0] WRAP = 7'(ENDLESS_WRAP);

    rsc_pkg::cfg_t cfg;

    rsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sensor state
    rsc_pkg::state_t mode_reg, mode_next;
    logic        intensity_reg, intensity_next;
    logic [13:0] win_start_reg, win_start_next;
    logic [13:0] win_end_reg, win_end_next;
    logic [6:0]  group_reg, group_next;
    logic [3:0]  skip_limit_reg, skip_limit_next;
    logic [6:0]  scan_limit_reg, scan_limit_next;
    logic [3:0]  skip_cnt_reg, skip_cnt_next;
    logic [6:0]  sent_cnt_reg, sent_cnt_next;
    logic [31:0] last_rb_reg, last_rb_next;
    logic        rb_seen_reg, rb_seen_next;
    logic [15:0] boot_cnt_reg, boot_cnt_next;

    // result register
    logic        out_valid_reg;
    logic        reply_valid_reg, reply_valid_next;
    rsc_pkg::status_t status_reg, status_next;
    rsc_pkg::state_t  state_out_reg;
    logic        tstamp_reg, tstamp_next;
    logic [6:0]  left_reg, left_next;
    logic        fint_reg, fint_next;
    logic        epoch_reg, epoch_next;
    logic        rbs_reg, rbs_next;
    logic [15:0] boots_reg;

    logic        accept;
    logic        len_err;
    logic        st_err;
    logic        mx_order_err;
    logic        mx_range_err;
    logic        rb_first;
    logic [31:0] rb_gap;
    logic [4:0]  skip_p1;
    logic        tick_fire;
    logic [7:0]  sent_p1;
    logic [6:0]  sent_inc;

    assign cmd.ready = !out_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign len_err      = cmd.length_status != rsc_pkg::LEN_OK;
    assign st_err       = mode_reg == rsc_pkg::ST_ERROR;
    assign mx_order_err = cmd.start_step > cmd.end_step;
    assign mx_range_err = (cmd.start_step < cfg.min_step) || (cmd.end_step > cfg.max_step);
    assign rb_gap       = cmd.now_ms - last_rb_reg;
    assign rb_first     = !rb_seen_reg || (rb_gap > {16'd0, cfg.reboot_window_ms});
    assign skip_p1      = {1'b0, skip_cnt_reg} + 5'd1;
    assign tick_fire    = (mode_reg == rsc_pkg::ST_MULTI) && (skip_p1 > {1'b0, skip_limit_reg});
    assign sent_p1      = {1'b0, sent_cnt_reg} + 8'd1;
    // sent counter increment saturates at 127 rather than wrapping past the 7-bit range
    assign sent_inc     = (sent_cnt_reg != 7'd127) ? sent_p1[6:0] : sent_cnt_reg;

    // next sensor state
    always_comb
    begin
        mode_next = mode_reg;
        case (cmd.kind)
            rsc_pkg::K_BM:
                if (!len_err && mode_reg == rsc_pkg::ST_IDLE)
                    mode_next = rsc_pkg::ST_SINGLE;
            rsc_pkg::K_QT:
                if (!len_err && !st_err &&
                    (mode_reg inside {rsc_pkg::ST_SINGLE, rsc_pkg::ST_MULTI, rsc_pkg::ST_IDLE}))
                    mode_next = rsc_pkg::ST_IDLE;
            rsc_pkg::K_RS:
                if (!len_err && !st_err)
                    mode_next = rsc_pkg::ST_IDLE;
            rsc_pkg::K_TM:
                if (!len_err && !st_err)
                begin
                    if (cmd.tm_sub == rsc_pkg::TM_ENTER &&
                        (mode_reg inside {rsc_pkg::ST_IDLE, rsc_pkg::ST_SINGLE}))
                        mode_next = rsc_pkg::ST_TIMEADJ;
                    else if (cmd.tm_sub == rsc_pkg::TM_LEAVE && mode_reg == rsc_pkg::ST_TIMEADJ)
                        mode_next = rsc_pkg::ST_IDLE;
                end
            rsc_pkg::K_MX:
                if (!len_err && cmd.fields_valid && !mx_order_err && !mx_range_err)
                    mode_next = rsc_pkg::ST_MULTI;
            rsc_pkg::K_SCAN_TICK:
                if (tick_fire && scan_limit_reg != 7'd0 && sent_inc >= scan_limit_reg)
                    mode_next = rsc_pkg::ST_IDLE;
            rsc_pkg::K_REBOOT_START:
                mode_next = rsc_pkg::ST_BOOTING;
            rsc_pkg::K_BOOT_DONE:
                mode_next = rsc_pkg::ST_IDLE;
            rsc_pkg::K_DISCONNECT:
                if (!(mode_reg inside {rsc_pkg::ST_BOOTING, rsc_pkg::ST_ERROR}))
                    mode_next = rsc_pkg::ST_IDLE;
            rsc_pkg::K_FORCE_STATE:
                if (cmd.forced_state <= 3'(rsc_pkg::ST_ERROR))
                    mode_next = rsc_pkg::state_t'(cmd.forced_state);
            default: ;
        endcase
    end

    // reply fields, settings and counters
    always_comb
    begin
        reply_valid_next = 1'b0;
        status_next      = rsc_pkg::S_00;
        tstamp_next      = 1'b0;
        left_next        = 7'd0;
        fint_next        = 1'b0;
        epoch_next       = 1'b0;
        rbs_next         = 1'b0;
        intensity_next   = intensity_reg;
        win_start_next   = win_start_reg;
        win_end_next     = win_end_reg;
        group_next       = group_reg;
        skip_limit_next  = skip_limit_reg;
        scan_limit_next  = scan_limit_reg;
        skip_cnt_next    = skip_cnt_reg;
        sent_cnt_next    = sent_cnt_reg;
        last_rb_next     = last_rb_reg;
        rb_seen_next     = rb_seen_reg;
        boot_cnt_next    = boot_cnt_reg;

        if ((cmd.kind inside {[rsc_pkg::K_BM:rsc_pkg::K_RB]}) && len_err)
        begin
            reply_valid_next = 1'b1;
            status_next = (cmd.length_status == rsc_pkg::LEN_SHORT) ? rsc_pkg::S_0C
                                                                     : rsc_pkg::S_0D;
        end
        else
        begin
            case (cmd.kind)
                rsc_pkg::K_BM:
                begin
                    reply_valid_next = 1'b1;
                    if (st_err)
                        status_next = rsc_pkg::S_0L;
                    else if (mode_reg == rsc_pkg::ST_IDLE)
                        status_next = rsc_pkg::S_00;
                    else if (mode_reg inside {rsc_pkg::ST_SINGLE, rsc_pkg::ST_MULTI})
                        status_next = rsc_pkg::S_02;
                    else
                        status_next = rsc_pkg::S_10;
                end
                rsc_pkg::K_QT:
                begin
                    reply_valid_next = 1'b1;
                    if (st_err)
                        status_next = rsc_pkg::S_0L;
                    else if (mode_reg inside {rsc_pkg::ST_SINGLE, rsc_pkg::ST_MULTI,
                                              rsc_pkg::ST_IDLE})
                        status_next = rsc_pkg::S_00;
                    else
                        status_next = rsc_pkg::S_10;
                end
                rsc_pkg::K_RS:
                begin
                    reply_valid_next = 1'b1;
                    if (st_err)
                        status_next = rsc_pkg::S_0L;
                    else
                        epoch_next = 1'b1;
                end
                rsc_pkg::K_TM:
                begin
                    reply_valid_next = 1'b1;
                    if (st_err)
                        status_next = rsc_pkg::S_0L;
                    else
                    begin
                        case (cmd.tm_sub)
                            rsc_pkg::TM_ENTER:
                                if (mode_reg inside {rsc_pkg::ST_IDLE, rsc_pkg::ST_SINGLE})
                                    status_next = rsc_pkg::S_00;
                                else if (mode_reg == rsc_pkg::ST_TIMEADJ)
                                    status_next = rsc_pkg::S_02;
                                else
                                    status_next = rsc_pkg::S_10;
                            rsc_pkg::TM_READ:
                                tstamp_next = 1'b1;
                            rsc_pkg::TM_LEAVE:
                                if (mode_reg == rsc_pkg::ST_TIMEADJ)
                                    status_next = rsc_pkg::S_00;
                                else if (mode_reg == rsc_pkg::ST_IDLE)
                                    status_next = rsc_pkg::S_03;
                                else
                                    status_next = rsc_pkg::S_10;
                            default:
                                status_next = rsc_pkg::S_01;
                        endcase
                    end
                end
                rsc_pkg::K_MX:
                begin
                    reply_valid_next = 1'b1;
                    if (!cmd.fields_valid)
                        status_next = rsc_pkg::S_02;
                    else
                    begin
                        // a rejected window is still loaded; only the run is not started
                        win_start_next  = cmd.start_step;
                        win_end_next    = cmd.end_step;
                        group_next      = (cmd.group_size == 7'd0) ? 7'd1 : cmd.group_size;
                        skip_limit_next = cmd.skip_scans;
                        scan_limit_next = cmd.scan_total;
                        if (mx_order_err)
                            status_next = rsc_pkg::S_05;
                        else if (mx_range_err)
                            status_next = rsc_pkg::S_04;
                        else
                        begin
                            skip_cnt_next  = 4'd0;
                            sent_cnt_next  = 7'd0;
                            intensity_next = cmd.with_intensity;
                        end
                    end
                end
                rsc_pkg::K_RB:
                begin
                    reply_valid_next = 1'b1;
                    if (rb_first)
                    begin
                        status_next  = rsc_pkg::S_01;
                        last_rb_next = cmd.now_ms;
                        rb_seen_next = 1'b1;
                    end
                    else
                        rbs_next = 1'b1;
                end
                rsc_pkg::K_UNKNOWN:
                begin
                    reply_valid_next = 1'b1;
                    status_next      = rsc_pkg::S_0E;
                end
                rsc_pkg::K_SCAN_TICK:
                    if (mode_reg == rsc_pkg::ST_MULTI)
                    begin
                        if (tick_fire)
                        begin
                            reply_valid_next = 1'b1;
                            status_next      = rsc_pkg::S_99;
                            fint_next        = intensity_reg;
                            if (scan_limit_reg != 7'd0 && {1'b0, scan_limit_reg} > sent_p1)
                                left_next = scan_limit_reg - sent_cnt_reg - 7'd1;
                            skip_cnt_next = 4'd0;
                            sent_cnt_next = sent_inc;
                            if (scan_limit_reg == 7'd0 && sent_inc >= WRAP)
                                sent_cnt_next = 7'd0;
                        end
                        else
                            skip_cnt_next = skip_p1[3:0];
                    end
                rsc_pkg::K_BOOT_DONE:
                    boot_cnt_next = boot_cnt_reg + 16'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= rsc_pkg::ST_BOOTING;
            intensity_reg  <= 1'b0;
            win_start_reg  <= 14'd0;
            win_end_reg    <= 14'd0;
            group_reg      <= 7'd1;
            skip_limit_reg <= 4'd0;
            scan_limit_reg <= 7'd0;
            skip_cnt_reg   <= 4'd0;
            sent_cnt_reg   <= 7'd0;
            last_rb_reg    <= 32'd0;
            rb_seen_reg    <= 1'b0;
            boot_cnt_reg   <= 16'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg       <= mode_next;
                intensity_reg  <= intensity_next;
                win_start_reg  <= win_start_next;
                win_end_reg    <= win_end_next;
                group_reg      <= group_next;
                skip_limit_reg <= skip_limit_next;
                scan_limit_reg <= scan_limit_next;
                skip_cnt_reg   <= skip_cnt_next;
                sent_cnt_reg   <= sent_cnt_next;
                last_rb_reg    <= last_rb_next;
                rb_seen_reg    <= rb_seen_next;
                boot_cnt_reg   <= boot_cnt_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            reply_valid_reg <= reply_valid_next;
            status_reg      <= status_next;
            state_out_reg   <= mode_next;
            tstamp_reg      <= tstamp_next;
            left_reg        <= left_next;
            fint_reg        <= fint_next;
            epoch_reg       <= epoch_next;
            rbs_reg         <= rbs_next;
            boots_reg       <= boot_cnt_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.reply_valid      = reply_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.sensor_state     = state_out_reg;
    assign rsp.send_timestamp   = tstamp_reg;
    assign rsp.scans_left       = left_reg;
    assign rsp.frame_intensity  = fint_reg;
    assign rsp.epoch_reset      = epoch_reg;
    assign rsp.reboot_scheduled = rbs_reg;
    assign rsp.boots            = boots_reg;

`ifndef NO_ASSERTIONS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |-> !cmd.ready)
        else $error("input taken while a result is stalled");

    a_quiet_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.reply_valid |-> rsp.status == rsc_pkg::S_00)
        else $error("status set on a beat without a reply");

    a_left_only_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.scans_left != 7'd0 |-> rsp.status == rsc_pkg::S_99)
        else $error("scans_left outside a scan frame");

    a_boot_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.kind == rsc_pkg::K_BOOT_DONE
        |=> boot_cnt_reg == $past(boot_cnt_reg) + 16'd1 && mode_reg == rsc_pkg::ST_IDLE)
        else $error("boot done did not count a boot");

    a_state_echo: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.sensor_state == mode_reg && rsp.boots == boot_cnt_reg)
        else $error("result does not match the updated state");
`endif

endmodule
